// ===== src/ladder_rotary_switch_decoder_assert.svh =====
// ============================================================================
// Assertion macros for the ladder rotary switch decoder
// Short forms for clocked implication checks that are disabled during reset.
// ============================================================================
`ifndef LADDER_ROTARY_SWITCH_DECODER_ASSERT_SVH
`define LADDER_ROTARY_SWITCH_DECODER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define LRSD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ladder rotary switch decoder: assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define LRSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ladder rotary switch decoder: assertion failed");

`endif

// ===== src/lrsd_pkg.sv =====
// ============================================================================
// lrsd_pkg
// Shared widths, codes and types of the ladder rotary switch decoder.
// ============================================================================
package lrsd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int POS_W     = 4;
    localparam int DIR_W     = 2;
    localparam int NUMPOS_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POSITIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 2'd2;

    // Configuration reset values.
    localparam logic [NUMPOS_W-1:0] NUM_POSITIONS_RST = 5'd8;
    localparam logic [CFG_W-1:0]    SEGMENT_SIZE_RST  = 12'd585;
    localparam logic [CFG_W-1:0]    TOLERANCE_RST     = 12'd292;

    // Outcome of one classification.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             clockwise;
    } decision_t;

endpackage

// ===== src/lrsd_classify.sv =====
// ============================================================================
// lrsd_classify
// Threshold table built from the configuration, position decode of an average
// and the shorter-way-round direction test against the present position.
// ============================================================================
module lrsd_classify #(
    parameter int MAX_POSITIONS = 16
) (
    input  logic                           aclk,
    input  logic [lrsd_pkg::NUMPOS_W-1:0]  num_positions,
    input  logic [lrsd_pkg::CFG_W-1:0]     segment_size,
    input  logic [lrsd_pkg::CFG_W-1:0]     tolerance,
    input  logic [lrsd_pkg::SAMPLE_W-1:0]  average,
    input  logic [lrsd_pkg::POS_W-1:0]     cur_position,
    output lrsd_pkg::decision_t            decision
);

    localparam int NW    = $clog2(MAX_POSITIONS + 1);
    localparam int THR_W = lrsd_pkg::CFG_W + $clog2(MAX_POSITIONS) + 1;
    localparam int RW    = 9;

    logic [THR_W-1:0] thr_reg  [MAX_POSITIONS];
    logic [THR_W-1:0] thr_next [MAX_POSITIONS];
    logic [NW-1:0]    ring_reg;
    logic [NW-1:0]    ring_next;

    logic [lrsd_pkg::POS_W-1:0] new_pos;
    logic [RW-1:0]              from_rem;
    logic [RW-1:0]              step;
    logic [RW-1:0]              ring_w;
    logic [RW-1:0]              fwd_dist;

    // Thresholds and ring size are registered from the configuration and follow it
    // in the next cycle, so the compare path sees only registered values.
    always_comb begin
        for (int i = 0; i < MAX_POSITIONS; i++) begin
            thr_next[i] = THR_W'(i) * THR_W'(segment_size) + THR_W'(tolerance);
        end
        if (num_positions > lrsd_pkg::NUMPOS_W'(MAX_POSITIONS)) begin
            ring_next = NW'(MAX_POSITIONS);
        end else if (num_positions == '0) begin
            ring_next = NW'(1);
        end else begin
            ring_next = NW'(num_positions);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_POSITIONS; i++) begin
            thr_reg[i] <= thr_next[i];
        end
        ring_reg <= ring_next;
    end

    // The lowest passing threshold wins, so scan from the top down.
    always_comb begin
        new_pos = '0;
        for (int i = MAX_POSITIONS - 1; i >= 0; i--) begin
            if ((NW'(i) < ring_reg) && (THR_W'(average) < thr_reg[i])) begin
                new_pos = lrsd_pkg::POS_W'(ring_reg - NW'(i) - NW'(1));
            end
        end
    end

    // The old position may lie beyond a shrunken ring, so it is reduced
    // modulo the ring size by four restoring subtract steps first.
    always_comb begin
        ring_w   = RW'(ring_reg);
        from_rem = RW'(cur_position);
        for (int k = 3; k >= 0; k--) begin
            step = ring_w << k;
            if (from_rem >= step) begin
                from_rem = from_rem - step;
            end
        end
        if (RW'(new_pos) >= from_rem) begin
            fwd_dist = RW'(new_pos) - from_rem;
        end else begin
            fwd_dist = RW'(new_pos) + ring_w - from_rem;
        end
        decision.position  = new_pos;
        decision.clockwise = (fwd_dist <= (ring_w >> 1));
    end

endmodule

// ===== src/ladder_rotary_switch_decoder.sv =====
// ============================================================================
// ladder_rotary_switch_decoder
// Averages groups of ladder ADC samples, decodes the switch position and
// latches the direction of the last move.
// ============================================================================
// An accepted item passes through the input register, then the result register
// that also holds the decoder state; its result is valid there.
// Throughput: one item per cycle while the result side keeps taking items.
// Reset clears the average, sample count, position and direction to zero and
// returns the configuration registers to their defaults; no clearing pass.
module ladder_rotary_switch_decoder #(
    parameter int AVG_STEPS     = 100,
    parameter int MAX_POSITIONS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrsd_pkg::CFG_W-1:0]      cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [lrsd_pkg::SAMPLE_W-1:0]   s_sample,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lrsd_pkg::POS_W-1:0]      m_position,
    output logic [lrsd_pkg::DIR_W-1:0]      m_direction,
    output logic [lrsd_pkg::SAMPLE_W-1:0]   m_average,
    output logic                            m_updated
);

    `include "ladder_rotary_switch_decoder_assert.svh"

    localparam int CNT_W = $clog2(AVG_STEPS + 1);

    // Configuration.
    logic [lrsd_pkg::NUMPOS_W-1:0] num_pos_reg;
    logic [lrsd_pkg::CFG_W-1:0]    seg_reg;
    logic [lrsd_pkg::CFG_W-1:0]    tol_reg;

    // Input stage.
    logic                          in_valid_reg, in_valid_next;
    logic                          in_kind_reg;
    logic [lrsd_pkg::SAMPLE_W-1:0] in_sample_reg;

    // Decoder state, which doubles as the result register.
    logic                          out_valid_reg, out_valid_next;
    logic [lrsd_pkg::SAMPLE_W-1:0] avg_reg, avg_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [lrsd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [lrsd_pkg::DIR_W-1:0]    dir_reg, dir_next;
    logic                          updated_reg, updated_next;

    logic                          s_fire;
    logic                          advance;
    logic [lrsd_pkg::SAMPLE_W:0]   avg_sum;
    logic [lrsd_pkg::SAMPLE_W-1:0] avg_calc;
    lrsd_pkg::decision_t           decision;

    // Nothing is taken while reset is held.
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_pos_reg <= lrsd_pkg::NUM_POSITIONS_RST;
            seg_reg     <= lrsd_pkg::SEGMENT_SIZE_RST;
            tol_reg     <= lrsd_pkg::TOLERANCE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lrsd_pkg::CFG_NUM_POSITIONS: begin
                    num_pos_reg <= cfg_data[lrsd_pkg::NUMPOS_W-1:0];
                end
                lrsd_pkg::CFG_SEGMENT_SIZE: begin
                    seg_reg <= cfg_data;
                end
                lrsd_pkg::CFG_TOLERANCE: begin
                    tol_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // An item leaves the input stage whenever the result register is free or
    // being emptied in the same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);
    assign s_fire  = s_valid && s_ready;

    assign avg_sum  = {1'b0, avg_reg} + {1'b0, in_sample_reg};
    assign avg_calc = (cnt_reg == '0) ? in_sample_reg
                                      : avg_sum[lrsd_pkg::SAMPLE_W:1];

    lrsd_classify #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_classify (
        .aclk          (aclk),
        .num_positions (num_pos_reg),
        .segment_size  (seg_reg),
        .tolerance     (tol_reg),
        .average       (avg_calc),
        .cur_position  (pos_reg),
        .decision      (decision)
    );

    always_comb begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
        avg_next       = avg_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        updated_next   = updated_reg;
        if (advance) begin
            updated_next = 1'b0;
            if (in_kind_reg == lrsd_pkg::KIND_CLEAR) begin
                dir_next = lrsd_pkg::DIR_NONE;
            end else begin
                avg_next = avg_calc;
                if (cnt_reg == CNT_W'(AVG_STEPS)) begin
                    cnt_next     = '0;
                    updated_next = 1'b1;
                    if (decision.position != pos_reg) begin
                        pos_next = decision.position;
                        dir_next = decision.clockwise ? lrsd_pkg::DIR_CW
                                                      : lrsd_pkg::DIR_CCW;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            dir_reg       <= lrsd_pkg::DIR_NONE;
            updated_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            avg_reg       <= avg_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            updated_reg   <= updated_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_kind_reg   <= s_kind;
            in_sample_reg <= s_sample;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_position  = pos_reg;
    assign m_direction = dir_reg;
    assign m_average   = avg_reg;
    assign m_updated   = updated_reg;

    // A completed group always restarts the sample count.
    `LRSD_ASSERT_SAME(a_updated_restarts_group, aclk, aresetn,
        out_valid_reg && updated_reg, cnt_reg == '0)

    // A clear item leaves the direction at none.
    `LRSD_ASSERT_NEXT(a_clear_sets_none, aclk, aresetn,
        advance && (in_kind_reg == lrsd_pkg::KIND_CLEAR), dir_reg == lrsd_pkg::DIR_NONE)

    // A move of the position always latches a direction.
    `LRSD_ASSERT_NEXT(a_move_latches_direction, aclk, aresetn,
        pos_next != pos_reg, dir_reg != lrsd_pkg::DIR_NONE)

endmodule
